@@ src/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared constants and types of the bounding box accumulator
// Event kind codes, default widths, fixed point format and the control word
// that travels from the point generation stage to the accumulation stage.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BBA_COORD_WIDTH = 32;
    localparam int BBA_COUNT_WIDTH = 32;
    localparam int FRAC_BITS       = 16;
    localparam int KIND_WIDTH      = 4;
    localparam int PT_COUNT        = 4;

    localparam logic [KIND_WIDTH-1:0] KIND_POINT      = 4'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_LINE       = 4'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_JOIN       = 4'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_CIRCLE     = 4'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_TEXT       = 4'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_DRAW_PATH  = 4'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_SET_ENABLE = 4'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_CLEAR      = 4'd7;
    localparam logic [KIND_WIDTH-1:0] KIND_FINISH     = 4'd8;

    typedef struct packed {
        logic [KIND_WIDTH-1:0] kind;
        logic [PT_COUNT-1:0]   pt_valid;
        logic                  margin_en;
        logic                  enable_value;
    } bba_ctrl_t;

endpackage
`default_nettype wire

@@ src/bba_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_if: valid/ready channels of the bounding box accumulator
// Event words in, global box words out.
// ----------------------------------------------------------------------------
interface bba_item_if import bba_pkg::*; #(
    parameter int COORD_WIDTH = BBA_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         kind;
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] border_width;
    logic signed [COORD_WIDTH-1:0] scale;
    logic                          enable_value;

    modport source (
        output valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
               border_width, scale, enable_value,
        input  ready
    );
    modport sink (
        input  valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
               border_width, scale, enable_value,
        output ready
    );
endinterface

interface bba_result_if import bba_pkg::*; #(
    parameter int COORD_WIDTH = BBA_COORD_WIDTH,
    parameter int COUNT_WIDTH = BBA_COUNT_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic [COUNT_WIDTH-1:0]        point_count;
    logic                          positive_area;

    modport source (
        output valid, box_min_x, box_min_y, box_max_x, box_max_y,
               point_count, positive_area,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
               point_count, positive_area,
        output ready
    );
endinterface
`default_nettype wire

@@ src/bba_point_gen.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_point_gen: first stage, event to point list
// Expand one event into up to four saturated points and the stroke margin,
// and hold them in the stage register.
// ----------------------------------------------------------------------------
module bba_point_gen import bba_pkg::*; #(
    parameter int COORD_WIDTH = BBA_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [KIND_WIDTH-1:0]         kind,
    input  logic signed [COORD_WIDTH-1:0] p0_x,
    input  logic signed [COORD_WIDTH-1:0] p0_y,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] border_width,
    input  logic signed [COORD_WIDTH-1:0] scale,
    input  logic                          enable_value,
    output bba_ctrl_t                     ctrl,
    output logic signed [COORD_WIDTH-1:0] pt_x [PT_COUNT],
    output logic signed [COORD_WIDTH-1:0] pt_y [PT_COUNT],
    output logic signed [COORD_WIDTH-1:0] margin
);

    localparam int SH = FRAC_BITS + 1;
    localparam int PW = 2 * COORD_WIDTH - 1;
    localparam logic signed [COORD_WIDTH-1:0] C_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] C_ZERO = '0;
    localparam logic [PW-1:0] POS_LIM = {{COORD_WIDTH{1'b0}}, {(COORD_WIDTH-1){1'b1}}};

    function automatic logic signed [COORD_WIDTH-1:0] sat_add(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            sat_add = s[COORD_WIDTH] ? C_MIN : C_MAX;
        else
            sat_add = s[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_sub(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            sat_sub = s[COORD_WIDTH] ? C_MIN : C_MAX;
        else
            sat_sub = s[COORD_WIDTH-1:0];
    endfunction

    bba_ctrl_t                     ctrl_next;
    bba_ctrl_t                     ctrl_reg;
    logic signed [COORD_WIDTH-1:0] pt_x_next [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] pt_y_next [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] pt_x_reg [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] pt_y_reg [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] margin_next;
    logic signed [COORD_WIDTH-1:0] margin_reg;

    logic signed [COORD_WIDTH-1:0] va_x, va_y, vb_x, vb_y, cva_x, cva_y;
    logic [COORD_WIDTH-1:0]        scale_mag;
    logic [COORD_WIDTH-2:0]        width_mag;
    logic [PW-1:0]                 prod;
    logic [PW-1:0]                 shifted;
    logic                          ovf;
    logic                          neg;

    // Circle helper vectors: centre p0, radius points p1 and p2
    assign va_x  = sat_sub(p1_x, p0_x);
    assign va_y  = sat_sub(p1_y, p0_y);
    assign vb_x  = sat_sub(p2_x, p0_x);
    assign vb_y  = sat_sub(p2_y, p0_y);
    assign cva_x = sat_sub(p0_x, va_x);
    assign cva_y = sat_sub(p0_y, va_y);

    // Margin: scale * width / 2, truncated toward zero, width known positive
    assign scale_mag = scale[COORD_WIDTH-1]
                     ? (~$unsigned(scale)) + {{(COORD_WIDTH-1){1'b0}}, 1'b1}
                     : $unsigned(scale);
    assign width_mag = border_width[COORD_WIDTH-2:0];
    assign prod      = PW'(scale_mag) * PW'(width_mag);
    assign shifted   = prod >> SH;
    assign ovf       = shifted > POS_LIM;
    assign neg       = scale[COORD_WIDTH-1];

    always_comb
    begin
        if (ovf)
            margin_next = neg ? C_MIN : C_MAX;
        else if (neg)
            margin_next = C_ZERO - $signed(shifted[COORD_WIDTH-1:0]);
        else
            margin_next = $signed(shifted[COORD_WIDTH-1:0]);
    end

    always_comb
    begin
        ctrl_next.kind         = kind;
        ctrl_next.pt_valid     = '0;
        ctrl_next.margin_en    = 1'b0;
        ctrl_next.enable_value = enable_value;
        pt_x_next[0] = p0_x;
        pt_y_next[0] = p0_y;
        pt_x_next[1] = p1_x;
        pt_y_next[1] = p1_y;
        pt_x_next[2] = p2_x;
        pt_y_next[2] = p2_y;
        pt_x_next[3] = sat_sub(sat_add(p0_x, p2_x), p1_x);
        pt_y_next[3] = sat_sub(sat_add(p0_y, p2_y), p1_y);
        case (kind)
            KIND_POINT: ctrl_next.pt_valid = 4'b0001;
            KIND_LINE:  ctrl_next.pt_valid = 4'b0011;
            KIND_TEXT:  ctrl_next.pt_valid = 4'b0111;
            KIND_JOIN:  ctrl_next.pt_valid = 4'b1111;
            KIND_CIRCLE:
            begin
                ctrl_next.pt_valid = 4'b1111;
                pt_x_next[0] = sat_add(p1_x, vb_x);
                pt_y_next[0] = sat_add(p1_y, vb_y);
                pt_x_next[1] = sat_sub(p1_x, vb_x);
                pt_y_next[1] = sat_sub(p1_y, vb_y);
                pt_x_next[2] = sat_sub(cva_x, vb_x);
                pt_y_next[2] = sat_sub(cva_y, vb_y);
                pt_x_next[3] = sat_add(cva_x, vb_x);
                pt_y_next[3] = sat_add(cva_y, vb_y);
            end
            KIND_DRAW_PATH:
                ctrl_next.margin_en = !border_width[COORD_WIDTH-1] && (border_width != C_ZERO);
            default: ctrl_next.pt_valid = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg   <= ctrl_next;
            pt_x_reg   <= pt_x_next;
            pt_y_reg   <= pt_y_next;
            margin_reg <= margin_next;
        end
    end

    assign ctrl   = ctrl_reg;
    assign pt_x   = pt_x_reg;
    assign pt_y   = pt_y_reg;
    assign margin = margin_reg;

endmodule
`default_nettype wire

@@ src/bba_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_accum: second stage, local and global box state
// Fold the staged points into the local box, apply the stroke margin, fuse
// local into global and clear; the global box registers are the result word.
// ----------------------------------------------------------------------------
module bba_accum import bba_pkg::*; #(
    parameter int COORD_WIDTH = BBA_COORD_WIDTH,
    parameter int COUNT_WIDTH = BBA_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  bba_ctrl_t                     ctrl,
    input  logic signed [COORD_WIDTH-1:0] pt_x [PT_COUNT],
    input  logic signed [COORD_WIDTH-1:0] pt_y [PT_COUNT],
    input  logic signed [COORD_WIDTH-1:0] margin,
    output logic signed [COORD_WIDTH-1:0] box_min_x,
    output logic signed [COORD_WIDTH-1:0] box_min_y,
    output logic signed [COORD_WIDTH-1:0] box_max_x,
    output logic signed [COORD_WIDTH-1:0] box_max_y,
    output logic [COUNT_WIDTH-1:0]        point_count,
    output logic                          positive_area
);

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    function automatic logic signed [COORD_WIDTH-1:0] sat_add(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            sat_add = s[COORD_WIDTH] ? C_MIN : C_MAX;
        else
            sat_add = s[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_sub(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            sat_sub = s[COORD_WIDTH] ? C_MIN : C_MAX;
        else
            sat_sub = s[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] cnt_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [COUNT_WIDTH-1:0] b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        cnt_add = s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    endfunction

    logic signed [COORD_WIDTH-1:0] l_min_x_reg, l_min_y_reg, l_max_x_reg, l_max_y_reg;
    logic signed [COORD_WIDTH-1:0] l_min_x_next, l_min_y_next, l_max_x_next, l_max_y_next;
    logic signed [COORD_WIDTH-1:0] g_min_x_reg, g_min_y_reg, g_max_x_reg, g_max_y_reg;
    logic signed [COORD_WIDTH-1:0] g_min_x_next, g_min_y_next, g_max_x_next, g_max_y_next;
    logic [COUNT_WIDTH-1:0]        l_count_reg, l_count_next;
    logic [COUNT_WIDTH-1:0]        g_count_reg, g_count_next;
    logic                          en_reg, en_next;

    // point fold
    logic signed [COORD_WIDTH-1:0] p_min_x, p_min_y, p_max_x, p_max_y;
    logic [COUNT_WIDTH-1:0]        p_count;
    logic                          p_empty;

    // margin and fuse
    logic signed [COORD_WIDTH-1:0] s_min_x, s_min_y, s_max_x, s_max_y;
    logic signed [COORD_WIDTH-1:0] f1_min_x, f1_min_y, f1_max_x, f1_max_y;
    logic signed [COORD_WIDTH-1:0] f_min_x, f_min_y, f_max_x, f_max_y;
    logic [COUNT_WIDTH-1:0]        f_count;
    logic                          g_empty;

    always_comb
    begin
        p_min_x = l_min_x_reg;
        p_min_y = l_min_y_reg;
        p_max_x = l_max_x_reg;
        p_max_y = l_max_y_reg;
        p_empty = (l_count_reg == '0);
        for (int i = 0; i < PT_COUNT; i++)
        begin
            if (ctrl.pt_valid[i])
            begin
                if (p_empty)
                begin
                    p_min_x = pt_x[i];
                    p_max_x = pt_x[i];
                    p_min_y = pt_y[i];
                    p_max_y = pt_y[i];
                end
                else
                begin
                    if (pt_x[i] < p_min_x) p_min_x = pt_x[i];
                    if (pt_y[i] < p_min_y) p_min_y = pt_y[i];
                    if (pt_x[i] > p_max_x) p_max_x = pt_x[i];
                    if (pt_y[i] > p_max_y) p_max_y = pt_y[i];
                end
                p_empty = 1'b0;
            end
        end
        p_count = cnt_add(l_count_reg, COUNT_WIDTH'($countones(ctrl.pt_valid)));
    end

    // Grow local by the margin, then extend global by min corner, then max corner
    always_comb
    begin
        s_min_x = ctrl.margin_en ? sat_sub(l_min_x_reg, margin) : l_min_x_reg;
        s_min_y = ctrl.margin_en ? sat_sub(l_min_y_reg, margin) : l_min_y_reg;
        s_max_x = ctrl.margin_en ? sat_add(l_max_x_reg, margin) : l_max_x_reg;
        s_max_y = ctrl.margin_en ? sat_add(l_max_y_reg, margin) : l_max_y_reg;
        g_empty = (g_count_reg == '0);

        f1_min_x = (g_empty || s_min_x < g_min_x_reg) ? s_min_x : g_min_x_reg;
        f1_min_y = (g_empty || s_min_y < g_min_y_reg) ? s_min_y : g_min_y_reg;
        f1_max_x = (g_empty || s_min_x > g_max_x_reg) ? s_min_x : g_max_x_reg;
        f1_max_y = (g_empty || s_min_y > g_max_y_reg) ? s_min_y : g_max_y_reg;

        f_min_x = (s_max_x < f1_min_x) ? s_max_x : f1_min_x;
        f_min_y = (s_max_y < f1_min_y) ? s_max_y : f1_min_y;
        f_max_x = (s_max_x > f1_max_x) ? s_max_x : f1_max_x;
        f_max_y = (s_max_y > f1_max_y) ? s_max_y : f1_max_y;
        f_count = cnt_add(g_count_reg, l_count_reg);
    end

    always_comb
    begin
        l_min_x_next = l_min_x_reg;
        l_min_y_next = l_min_y_reg;
        l_max_x_next = l_max_x_reg;
        l_max_y_next = l_max_y_reg;
        l_count_next = l_count_reg;
        g_min_x_next = g_min_x_reg;
        g_min_y_next = g_min_y_reg;
        g_max_x_next = g_max_x_reg;
        g_max_y_next = g_max_y_reg;
        g_count_next = g_count_reg;
        en_next      = en_reg;
        case (ctrl.kind) inside
            KIND_POINT, KIND_LINE, KIND_JOIN, KIND_CIRCLE, KIND_TEXT:
            begin
                if (en_reg)
                begin
                    l_min_x_next = p_min_x;
                    l_min_y_next = p_min_y;
                    l_max_x_next = p_max_x;
                    l_max_y_next = p_max_y;
                    l_count_next = p_count;
                end
            end
            KIND_DRAW_PATH, KIND_FINISH:
            begin
                if (l_count_reg != '0)
                begin
                    g_min_x_next = f_min_x;
                    g_min_y_next = f_min_y;
                    g_max_x_next = f_max_x;
                    g_max_y_next = f_max_y;
                    g_count_next = f_count;
                end
                l_min_x_next = '0;
                l_min_y_next = '0;
                l_max_x_next = '0;
                l_max_y_next = '0;
                l_count_next = '0;
            end
            KIND_CLEAR:
            begin
                l_min_x_next = '0;
                l_min_y_next = '0;
                l_max_x_next = '0;
                l_max_y_next = '0;
                l_count_next = '0;
                g_min_x_next = '0;
                g_min_y_next = '0;
                g_max_x_next = '0;
                g_max_y_next = '0;
                g_count_next = '0;
            end
            KIND_SET_ENABLE: en_next = ctrl.enable_value;
            default: en_next = en_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_min_x_reg <= '0;
            l_min_y_reg <= '0;
            l_max_x_reg <= '0;
            l_max_y_reg <= '0;
            l_count_reg <= '0;
            g_min_x_reg <= '0;
            g_min_y_reg <= '0;
            g_max_x_reg <= '0;
            g_max_y_reg <= '0;
            g_count_reg <= '0;
            en_reg      <= 1'b1;
        end
        else if (fire)
        begin
            l_min_x_reg <= l_min_x_next;
            l_min_y_reg <= l_min_y_next;
            l_max_x_reg <= l_max_x_next;
            l_max_y_reg <= l_max_y_next;
            l_count_reg <= l_count_next;
            g_min_x_reg <= g_min_x_next;
            g_min_y_reg <= g_min_y_next;
            g_max_x_reg <= g_max_x_next;
            g_max_y_reg <= g_max_y_next;
            g_count_reg <= g_count_next;
            en_reg      <= en_next;
        end
    end

    assign box_min_x     = g_min_x_reg;
    assign box_min_y     = g_min_y_reg;
    assign box_max_x     = g_max_x_reg;
    assign box_max_y     = g_max_y_reg;
    assign point_count   = g_count_reg;
    assign positive_area = (g_max_x_reg > g_min_x_reg) && (g_max_y_reg > g_min_y_reg);

    a_local_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (ctrl.kind == KIND_DRAW_PATH || ctrl.kind == KIND_FINISH ||
                 ctrl.kind == KIND_CLEAR)
        |=> l_count_reg == '0)
        else $error("local box not cleared after fuse or clear");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ctrl.kind != KIND_CLEAR |=> g_count_reg >= $past(g_count_reg))
        else $error("global count dropped without clear");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(g_count_reg) && $stable(g_min_x_reg) &&
                  $stable(g_max_y_reg) && $stable(l_count_reg))
        else $error("box state moved without an event");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        g_count_reg == '0 |-> g_min_x_reg == '0 && g_min_y_reg == '0 &&
                              g_max_x_reg == '0 && g_max_y_reg == '0)
        else $error("empty global box is not zero");

    a_global_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        g_count_reg != '0 |-> g_min_x_reg <= g_max_x_reg && g_min_y_reg <= g_max_y_reg)
        else $error("non-empty global box inverted");

endmodule
`default_nettype wire

@@ src/bounding_box_accumulator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_box_accumulator: two-level 2D bounding box of a drawing stream
// Tracks a current-path box and a global box over Q16.16 drawing events and
// returns the global box, its point count and a positive-area flag per event.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Word contents                                   Handshake
//  item      in   kind, p0/p1/p2 x,y, border_width, scale, enable valid/ready
//  result    out  global min/max x,y, point_count, positive_area  valid/ready
//
//  One event word accepted per cycle, sustained while result is ready.
//  Between the edge that takes an event word and the first edge that can
//  take its result lie the point stage register (saturated corner points
//  and the 32x31 margin multiply), then the box state register, which also
//  serves as the result register.
//  The state update compares the staged points against the stored boxes
//  combinationally, so back-to-back events see each other's results.
//  Reset (rst_n low, asynchronous) empties both boxes and counts, enables
//  point capture and drops both stage valids; no clearing pass is needed.
//  A stall on result holds the state and result word; item stays ready while
//  the point stage is empty, so one event can wait behind a stalled result.
//
module bounding_box_accumulator import bba_pkg::*; #(
    parameter int COORD_WIDTH = BBA_COORD_WIDTH,
    parameter int COUNT_WIDTH = BBA_COUNT_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    bba_item_if.sink     item,
    bba_result_if.source result
);

    bba_ctrl_t                     ctrl;
    logic signed [COORD_WIDTH-1:0] pt_x [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] pt_y [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] margin;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic adv;
    logic take;
    logic fire;

    // Advance when the result slot is empty or being drained this cycle
    assign adv  = !out_valid_reg || result.ready;
    // Take a new word whenever the point stage will be free
    assign item.ready = adv || !s1_valid_reg;
    assign take = item.valid && item.ready;
    // Fold the staged word into the box state and present the result
    assign fire = s1_valid_reg && adv;

    always_comb
    begin
        s1_valid_next  = take ? 1'b1 : (s1_valid_reg && !fire);
        out_valid_next = fire || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    bba_point_gen #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_point_gen (
        .clk          (clk),
        .load         (take),
        .kind         (item.kind),
        .p0_x         (item.p0_x),
        .p0_y         (item.p0_y),
        .p1_x         (item.p1_x),
        .p1_y         (item.p1_y),
        .p2_x         (item.p2_x),
        .p2_y         (item.p2_y),
        .border_width (item.border_width),
        .scale        (item.scale),
        .enable_value (item.enable_value),
        .ctrl         (ctrl),
        .pt_x         (pt_x),
        .pt_y         (pt_y),
        .margin       (margin)
    );

    // Global box registers drive the result word directly; they only
    // change on fire, so a stalled word holds.
    bba_accum #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .ctrl          (ctrl),
        .pt_x          (pt_x),
        .pt_y          (pt_y),
        .margin        (margin),
        .box_min_x     (result.box_min_x),
        .box_min_y     (result.box_min_y),
        .box_max_x     (result.box_max_x),
        .box_max_y     (result.box_max_y),
        .point_count   (result.point_count),
        .positive_area (result.positive_area)
    );

    assign result.valid = out_valid_reg;

endmodule
`default_nettype wire
